FILE: design/pgr_pkg.sv
// Shared types and constants for the page replacement block.
// No dependencies; imported by pgr_cell and page_replacement_fifo_lru.
`default_nettype none
package pgr_pkg;

    localparam int FRAMES     = 8;
    localparam int PAGE_WIDTH = 8;

    localparam int IN_W    = 8;
    localparam int OUT_W   = 32;
    localparam int CNT_W   = 16;
    localparam int FC_W    = 4;
    localparam int OCC_W   = $clog2(FRAMES + 1);
    localparam int CMP_W   = (OCC_W > FC_W) ? OCC_W : FC_W;

    localparam logic [IN_W-1:0] PAGE_MASK =
        (PAGE_WIDTH >= IN_W) ? {IN_W{1'b1}} : IN_W'((64'd1 << PAGE_WIDTH) - 64'd1);

    localparam logic [FC_W-1:0]  FRAME_COUNT_RST = 4'd8;
    localparam logic             POLICY_RST      = 1'b1;
    localparam logic             POLICY_FIFO     = 1'b0;
    localparam logic             POLICY_LRU      = 1'b1;
    localparam logic [CNT_W-1:0] CNT_MAX         = {CNT_W{1'b1}};

    localparam logic REG_FRAME_COUNT = 1'b0;
    localparam logic REG_POLICY      = 1'b1;

    typedef logic [IN_W-1:0] t_page;

    typedef struct packed {
        logic in_use;
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: design/pgr_cell.sv
// One frame of the resident page list: holds a page, compares it to the key,
// and loads either the key or its neighbor's page. Depends on pgr_pkg.
`default_nettype none
module pgr_cell
    import pgr_pkg::*;
(
    input  wire        i_clk,
    input  t_cell_ctl  i_ctl,
    input  t_page      i_key,
    input  t_page      i_nbr_page,
    input  wire        i_seen,
    output t_page      o_page,
    output logic       o_seen
);

    t_page r_page;
    t_page n_page;
    logic  w_match;

    always_comb begin
        n_page = r_page;
        if (i_ctl.load) begin
            n_page = i_key;
        end else if (i_ctl.shift) begin
            n_page = i_nbr_page;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

    assign w_match = i_ctl.in_use && (r_page == i_key);
    assign o_seen  = i_seen | w_match;
    assign o_page  = r_page;

endmodule
`default_nettype wire

FILE: design/page_replacement_fifo_lru.sv
// Page replacement unit (FIFO / LRU) built as a row of frame cells.
// Depends on pgr_pkg and pgr_cell.
`default_nettype none
// One page reference is taken per clock. All frame cells compare the page in
// the cycle of the transfer, a hit position ripples along the cell row, and
// the list shifts toward the oldest end in the same cycle; the result is in
// the output register from the cycle after. Sustained rate is one item per
// cycle. Input is stalled only while the output register is full and not
// being taken.
module page_replacement_fifo_lru
    import pgr_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    // APB configuration
    input  wire              i_psel,
    input  wire              i_penable,
    input  wire              i_pwrite,
    input  wire  [2:0]       i_paddr,
    input  wire  [31:0]      i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready,
    // page references
    input  wire              i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire  [IN_W-1:0]  i_s_axis_tdata,   // [7:0] page_number
    // results
    output logic             o_m_axis_tvalid,
    input  wire              i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata    // [0] page_fault, [1] evict_valid,
                                               // [9:2] evicted_page, [25:10] fault_total
);

    logic [FC_W-1:0]  r_frame_count;
    logic             r_policy;
    logic [OCC_W-1:0] r_occ,  n_occ;
    logic [CNT_W-1:0] r_fcnt, n_fcnt;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data, n_out_data;

    t_page            w_key;
    t_page            w_page [FRAMES];
    logic             w_seen [FRAMES+1];
    t_cell_ctl        w_ctl  [FRAMES];

    logic             w_fire, w_hit, w_evict, w_shift_en, w_cfg_wr;
    logic [CMP_W-1:0] w_limit, w_occ_ext;

    // configuration
    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
            r_policy      <= POLICY_RST;
        end else if (w_cfg_wr) begin
            if (i_paddr[2] == REG_FRAME_COUNT) begin
                r_frame_count <= i_pwdata[FC_W-1:0];
            end else begin
                r_policy <= i_pwdata[0];
            end
        end
    end

    always_comb begin
        if (i_paddr[2] == REG_POLICY) begin
            o_prdata = {31'd0, r_policy};
        end else begin
            o_prdata = {{(32-FC_W){1'b0}}, r_frame_count};
        end
    end

    // frame limit clamped into 1..FRAMES
    always_comb begin
        if (r_frame_count == '0) begin
            w_limit = CMP_W'(1);
        end else if (CMP_W'(r_frame_count) > CMP_W'(FRAMES)) begin
            w_limit = CMP_W'(FRAMES);
        end else begin
            w_limit = CMP_W'(r_frame_count);
        end
    end

    assign w_occ_ext       = CMP_W'(r_occ);
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign w_key           = i_s_axis_tdata & PAGE_MASK;

    assign w_seen[0]  = 1'b0;
    assign w_hit      = w_seen[FRAMES];
    assign w_evict    = !w_hit && (w_occ_ext >= w_limit) && (r_occ != '0);
    assign w_shift_en = (w_hit && (r_policy == POLICY_LRU)) || w_evict;

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        always_comb begin
            w_ctl[g].in_use = OCC_W'(g) < r_occ;
            w_ctl[g].shift  = w_fire && w_shift_en && (OCC_W'(g + 1) < r_occ)
                              && (w_evict || w_seen[g+1]);
            if (w_shift_en) begin
                w_ctl[g].load = w_fire && (OCC_W'(g + 1) == r_occ);
            end else begin
                w_ctl[g].load = w_fire && !w_hit && (OCC_W'(g) == r_occ);
            end
        end

        if (g == FRAMES - 1) begin : g_last
            pgr_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[g]),
                .i_key      (w_key),
                .i_nbr_page ('0),
                .i_seen     (w_seen[g]),
                .o_page     (w_page[g]),
                .o_seen     (w_seen[g+1])
            );
        end else begin : g_mid
            pgr_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[g]),
                .i_key      (w_key),
                .i_nbr_page (w_page[g+1]),
                .i_seen     (w_seen[g]),
                .o_page     (w_page[g]),
                .o_seen     (w_seen[g+1])
            );
        end
    end

    always_comb begin
        n_occ      = r_occ;
        n_fcnt     = r_fcnt;
        n_out_data = r_out_data;
        if (w_fire) begin
            if (!w_hit) begin
                if (!w_evict) begin
                    n_occ = r_occ + OCC_W'(1);
                end
                if (r_fcnt != CNT_MAX) begin
                    n_fcnt = r_fcnt + CNT_W'(1);
                end
            end
            n_out_data = '0;
            n_out_data[0]     = !w_hit;
            n_out_data[1]     = w_evict;
            n_out_data[9:2]   = w_evict ? w_page[0] : '0;
            n_out_data[25:10] = n_fcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_fcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_occ  <= n_occ;
            r_fcnt <= n_fcnt;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_occ) <= CMP_W'(FRAMES))
        else $error("occupancy above frame count");

    a_fault_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_hit && r_fcnt != CNT_MAX) |=> (r_fcnt == $past(r_fcnt) + CNT_W'(1)))
        else $error("fault not counted");

    a_evict_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_evict) |=> (r_occ == $past(r_occ)))
        else $error("eviction changed occupancy");

endmodule
`default_nettype wire
